/* design/assert_macros.svh */
// assertion macros for the minimum coin change design
// no dependencies; included by mcc_datapath, which checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif
`endif

/* design/mcc_pkg.sv */
// types and constants for the minimum coin change table core
// no dependencies; used by mcc_ctrl, mcc_datapath and the top level
package mcc_pkg;

  localparam int unsigned TARGET_W   = 10;
  localparam int unsigned COIN_W     = 10;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned USE_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned COIN_REGS  = 5;
  localparam int unsigned NUM_COINS  = 5;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned TARGET_MAX = (1 << TARGET_W) - 1;

  localparam logic [COUNT_W-1:0]  UNREACH_MARK = 11'h7FF;
  localparam logic [COUNT_W-1:0]  COUNT_CAP    = 11'h7FE;
  localparam logic [TARGET_W-1:0] OUT_MAX      = 10'h3FF;

  localparam int unsigned ACTIVE_MAX_I = (NUM_COINS < COIN_REGS) ? NUM_COINS : COIN_REGS;
  localparam logic [USE_W-1:0] ACTIVE_MAX  = USE_W'(ACTIVE_MAX_I);
  localparam logic [USE_W-1:0] USE_RESET   = 3'd5;
  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(COIN_REGS);

  localparam logic [COIN_W-1:0] COIN_RESET [COIN_REGS] = '{10'd1, 10'd2, 10'd5, 10'd10, 10'd50};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COIN_0       = 3'd0,
    REG_COIN_1       = 3'd1,
    REG_COIN_2       = 3'd2,
    REG_COIN_3       = 3'd3,
    REG_COIN_4       = 3'd4,
    REG_COINS_IN_USE = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_FILL,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic run;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic direct;
    logic fill_done;
    logic out_free;
  } status_t;

endpackage

/* design/mcc_ctrl.sv */
// sequencer for the minimum coin change table core
// depends on mcc_pkg; drives mcc_datapath through cmd_t and reads status_t
module mcc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mcc_pkg::status_t st_i,
  output mcc_pkg::cmd_t    cmd_o
);
  import mcc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = st_i.direct ? S_EMIT : S_FILL;
      end
      S_FILL: begin
        cmd_o.run = 1'b1;
        if (st_i.fill_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* design/mcc_datapath.sv */
// coin registers, best count table memory and output register
// depends on mcc_pkg and assert_macros.svh; sequenced by mcc_ctrl
module mcc_datapath #(
  parameter int unsigned MAX_AMOUNT = 1023
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcc_pkg::COIN_W-1:0]     cfg_data_i,
  input  logic [mcc_pkg::TARGET_W-1:0]   target_amount_i,
  input  mcc_pkg::cmd_t                  cmd_i,
  output mcc_pkg::status_t               st_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mcc_pkg::TARGET_W-1:0]   min_coins_o,
  output logic                           unreachable_o
);
  import mcc_pkg::*;

  localparam int unsigned CAP_AMOUNT = (MAX_AMOUNT < TARGET_MAX) ? MAX_AMOUNT : TARGET_MAX;
  localparam int unsigned DEPTH      = CAP_AMOUNT + 1;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam logic [16:0] MAX_W      = 17'(MAX_AMOUNT);

  logic [COIN_W-1:0]   coin_q [COIN_REGS];
  logic [USE_W-1:0]    use_q;
  logic [COUNT_W-1:0]  mem [DEPTH];

  logic [TARGET_W-1:0] target_q, amount_q;
  logic [PHASE_W-1:0]  phase_q;
  logic [COUNT_W-1:0]  best_q, last_q, rd_data_q;
  logic                rd_valid_q, rd_zero_q;
  logic                out_valid_q, unreach_q;
  logic [TARGET_W-1:0] min_q;

  logic [USE_W-1:0]    n_active;
  logic [PHASE_W-1:0]  coin_idx;
  logic [COIN_W-1:0]   coin_sel;
  logic                issue, entry_end, wr_en, over, out_free;
  logic [TARGET_W-1:0] rd_addr;
  logic [COUNT_W-1:0]  prev, best_cmp, entry_val;

  always_comb begin
    n_active  = (use_q > ACTIVE_MAX) ? ACTIVE_MAX : use_q;
    entry_end = (phase_q == LAST_PHASE);
    coin_idx  = entry_end ? '0 : phase_q;
    coin_sel  = coin_q[coin_idx];
    issue     = cmd_i.run && !entry_end && (phase_q < PHASE_W'(n_active))
                && (coin_sel != '0) && (coin_sel <= amount_q);
    rd_addr   = amount_q - coin_sel;
    prev      = rd_zero_q ? '0 : rd_data_q;
    best_cmp  = (rd_valid_q && (prev < best_q)) ? prev : best_q;
    if (best_cmp == UNREACH_MARK) begin
      entry_val = UNREACH_MARK;
    end else if (best_cmp >= COUNT_CAP) begin
      entry_val = COUNT_CAP;
    end else begin
      entry_val = best_cmp + COUNT_W'(1);
    end
    wr_en     = cmd_i.run && entry_end;
    over      = ({7'd0, target_q} > MAX_W);
    out_free  = !out_valid_q || out_ready_i;
  end

  assign st_o.direct    = (target_q == '0) || over;
  assign st_o.fill_done = entry_end && (amount_q == target_q);
  assign st_o.out_free  = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coin_q <= COIN_RESET;
      use_q  <= USE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i) inside
        REG_COIN_0, REG_COIN_1, REG_COIN_2, REG_COIN_3, REG_COIN_4: begin
          coin_q[cfg_idx_i] <= cfg_data_i;
        end
        REG_COINS_IN_USE: use_q <= cfg_data_i[USE_W-1:0];
        default: ;
      endcase
    end
  end

  // table memory, entry zero is never written; a read of it is replaced by zero
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[amount_q[AW-1:0]] <= entry_val;
    end
    if (issue) begin
      rd_data_q <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      amount_q   <= '0;
      phase_q    <= '0;
      best_q     <= UNREACH_MARK;
      last_q     <= '0;
      rd_valid_q <= 1'b0;
      rd_zero_q  <= 1'b0;
    end else if (cmd_i.load) begin
      target_q   <= target_amount_i;
      amount_q   <= TARGET_W'(1);
      phase_q    <= '0;
      best_q     <= UNREACH_MARK;
      last_q     <= '0;
      rd_valid_q <= 1'b0;
    end else if (cmd_i.run) begin
      rd_valid_q <= issue;
      rd_zero_q  <= (rd_addr == '0);
      if (entry_end) begin
        phase_q  <= '0;
        amount_q <= amount_q + TARGET_W'(1);
        best_q   <= UNREACH_MARK;
        last_q   <= entry_val;
      end else begin
        phase_q  <= phase_q + PHASE_W'(1);
        best_q   <= best_cmp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (over || (last_q == UNREACH_MARK)) begin
        min_q     <= '0;
        unreach_q <= 1'b1;
      end else begin
        min_q     <= (last_q > {1'b0, OUT_MAX}) ? OUT_MAX : last_q[TARGET_W-1:0];
        unreach_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign min_coins_o   = min_q;
  assign unreachable_o = unreach_q;

  `include "assert_macros.svh"

  `ASSERT_AT(a_phase_range, clk_i, rst_ni, phase_q <= LAST_PHASE, "phase beyond last coin")
  `ASSERT_AT(a_write_in_range, clk_i, rst_ni, wr_en |-> (amount_q != '0) && (amount_q <= target_q), "table write outside fill range")
  `ASSERT_NEVER(a_emit_overwrite, clk_i, rst_ni, cmd_i.emit && out_valid_q && !out_ready_i, "result overwritten before taken")
  `ASSERT_AT(a_read_from_issue, clk_i, rst_ni, rd_valid_q |-> $past(issue), "read data without a read issued")

endmodule

/* design/min_coin_change_table_core.sv */
// minimum coin change table core: for a target T it fills table entries one through T in
// order; each entry steps through the five coin registers, reading the single table read port
// for each coin in use that fits, then writes the entry (T of zero or beyond capacity: no fill)
// one item is worked at a time; the next is accepted once the last result has been emitted
// a finished result waits in the output register; an untaken one holds the next emit
// reset: coins 1, 2, 5, 10, 50 with five in use; the table is not cleared, entry zero is a constant
module min_coin_change_table_core #(
  parameter int unsigned MAX_AMOUNT = 1023
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcc_pkg::COIN_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mcc_pkg::TARGET_W-1:0]   target_amount_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mcc_pkg::TARGET_W-1:0]   min_coins_o,
  output logic                           unreachable_o
);
  import mcc_pkg::*;

  cmd_t    cmd;
  status_t st;

  mcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  mcc_datapath #(
    .MAX_AMOUNT (MAX_AMOUNT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .target_amount_i (target_amount_i),
    .cmd_i           (cmd),
    .st_o            (st),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .min_coins_o     (min_coins_o),
    .unreachable_o   (unreachable_o)
  );

endmodule

/* verif/testbench.sv */
// testbench for min_coin_change_table_core: directed table, then random items
// under three idling mixes; depends on design/mcc_pkg.sv and the core
// results checked against a local table-filling predictor
`timescale 1ns / 100ps

module testbench;
  import mcc_pkg::*;

  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned MAX_AMOUNT    = 1023;
  localparam int unsigned RST_CYCLES    = 6;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned SETTINGS_PER_PHASE = 3;
  localparam int unsigned ITEMS_PER_SETTING  = 10;

  typedef struct {
    logic [TARGET_W-1:0] amount;
    logic [TARGET_W-1:0] coins;
    logic                unreach;
  } change_res_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    cfg_reg_e            idx;
    logic [COIN_W-1:0]   val;
    logic                known;
    logic [TARGET_W-1:0] coins;
    logic                unreach;
  } stim_row_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i       = '0;
  logic [COIN_W-1:0]    cfg_data_i      = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_ready_o;
  logic [TARGET_W-1:0]  target_amount_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i     = 1'b0;
  logic [TARGET_W-1:0]  min_coins_o;
  logic                 unreachable_o;

  logic [COIN_W-1:0] coin_val [COIN_REGS];
  logic [USE_W-1:0]  coins_used;
  change_res_t       change_due [$];
  stim_row_t         dir_rows [$];

  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 53;
  int unsigned cycle_cnt     = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned reg_writes    = 0;
  int unsigned settings_seen = 1;
  int unsigned bad_results   = 0;

  min_coin_change_table_core #(
    .MAX_AMOUNT(MAX_AMOUNT)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .target_amount_i(target_amount_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .min_coins_o    (min_coins_o),
    .unreachable_o  (unreachable_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, change_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  // fewest coins for an amount, filling the count table from one upwards
  function automatic change_res_t min_change(input logic [TARGET_W-1:0] amount);
    logic [COUNT_W-1:0] tally [MAX_AMOUNT + 1];
    logic [COUNT_W-1:0] low;
    int unsigned        n;
    change_res_t        res;
    n = coins_used;
    if (n > NUM_COINS) n = NUM_COINS;
    if (n > COIN_REGS) n = COIN_REGS;
    tally[0] = '0;
    for (int a = 1; a <= int'(amount); a++) begin
      low = UNREACH_MARK;
      for (int j = 0; j < int'(n); j++) begin
        if (coin_val[j] != 0 && int'(coin_val[j]) <= a && tally[a - int'(coin_val[j])] < low) begin
          low = tally[a - int'(coin_val[j])];
        end
      end
      if (low == UNREACH_MARK) tally[a] = UNREACH_MARK;
      else if (low >= COUNT_CAP) tally[a] = COUNT_CAP;
      else tally[a] = low + 1'b1;
    end
    res.amount = amount;
    if (tally[amount] == UNREACH_MARK) begin
      res.coins   = '0;
      res.unreach = 1'b1;
    end else begin
      res.coins   = (tally[amount] > COUNT_W'(OUT_MAX)) ? OUT_MAX : tally[amount][TARGET_W-1:0];
      res.unreach = 1'b0;
    end
    return res;
  endfunction

  function automatic stim_row_t row_item(input logic [TARGET_W-1:0] t);
    stim_row_t r;
    r = '{ROW_ITEM, REG_COIN_0, t, 1'b0, '0, 1'b0};
    return r;
  endfunction

  function automatic stim_row_t row_known(input logic [TARGET_W-1:0] t,
                                          input logic [TARGET_W-1:0] c, input logic u);
    stim_row_t r;
    r = '{ROW_ITEM, REG_COIN_0, t, 1'b1, c, u};
    return r;
  endfunction

  function automatic stim_row_t row_reg(input cfg_reg_e idx, input logic [COIN_W-1:0] v);
    stim_row_t r;
    r = '{ROW_REG, idx, v, 1'b0, '0, 1'b0};
    return r;
  endfunction

  // result side: random back-pressure and in-order compare
  always @(posedge clk_i) begin
    change_res_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      results_seen <= results_seen + 1;
      if (change_due.size() == 0) begin
        bad_results <= bad_results + 1;
        if (bad_results < MAX_REPORTS) begin
          $display("unexpected result: min_coins %0d unreachable %0b", min_coins_o, unreachable_o);
        end
      end else begin
        want = change_due.pop_front();
        if (min_coins_o !== want.coins || unreachable_o !== want.unreach) begin
          bad_results <= bad_results + 1;
          if (bad_results < MAX_REPORTS) begin
            $display("mismatch for amount %0d: expected %0d/%0b, got %0d/%0b", want.amount,
                     want.coins, want.unreach, min_coins_o, unreachable_o);
          end
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic push_target(input logic [TARGET_W-1:0] t, input logic known,
                             input logic [TARGET_W-1:0] c, input logic u);
    change_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    target_amount_i <= t;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (known) res = '{t, c, u};
    else res = min_change(t);
    change_due.push_back(res);
    items_sent++;
  endtask

  // hold off the sender until every outstanding item has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (change_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [COIN_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_COINS_IN_USE) coins_used = val[USE_W-1:0];
    else coin_val[idx] = val;
    reg_writes++;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned         r;
    logic [COIN_W-1:0]   v;
    logic [TARGET_W-1:0] t;
    stim_row_t           row;
    logic                last_reg;

    for (int i = 0; i < int'(COIN_REGS); i++) coin_val[i] = COIN_RESET[i];
    coins_used = USE_RESET;

    // after reset: coins 1, 2, 5, 10, 50
    dir_rows.push_back(row_known(10'd0, 10'd0, 1'b0));
    dir_rows.push_back(row_known(10'd1, 10'd1, 1'b0));
    dir_rows.push_back(row_known(10'd50, 10'd1, 1'b0));
    dir_rows.push_back(row_item(10'd3));
    dir_rows.push_back(row_item(10'd99));
    dir_rows.push_back(row_item(10'd1023));
    // no coins in use
    dir_rows.push_back(row_reg(REG_COINS_IN_USE, 10'd0));
    dir_rows.push_back(row_known(10'd7, 10'd0, 1'b1));
    dir_rows.push_back(row_known(10'd0, 10'd0, 1'b0));
    dir_rows.push_back(row_known(10'd1023, 10'd0, 1'b1));
    // coin count above the limit
    dir_rows.push_back(row_reg(REG_COINS_IN_USE, 10'd7));
    dir_rows.push_back(row_item(10'd63));
    dir_rows.push_back(row_item(10'd512));
    // zero-valued coin ignored
    dir_rows.push_back(row_reg(REG_COIN_0, 10'd0));
    dir_rows.push_back(row_reg(REG_COINS_IN_USE, 10'd1));
    dir_rows.push_back(row_known(10'd5, 10'd0, 1'b1));
    // largest coin value
    dir_rows.push_back(row_reg(REG_COIN_0, 10'd1023));
    dir_rows.push_back(row_known(10'd1023, 10'd1, 1'b0));
    dir_rows.push_back(row_known(10'd1022, 10'd0, 1'b1));
    // unit coin alone gives the largest count
    dir_rows.push_back(row_reg(REG_COIN_0, 10'd1));
    dir_rows.push_back(row_known(10'd1023, 10'd1023, 1'b0));
    // odd denominations with gaps
    dir_rows.push_back(row_reg(REG_COIN_0, 10'd3));
    dir_rows.push_back(row_reg(REG_COIN_1, 10'd7));
    dir_rows.push_back(row_reg(REG_COIN_2, 10'd0));
    dir_rows.push_back(row_reg(REG_COIN_3, 10'd1023));
    dir_rows.push_back(row_reg(REG_COIN_4, 10'd1));
    dir_rows.push_back(row_reg(REG_COINS_IN_USE, 10'd4));
    dir_rows.push_back(row_item(10'd11));
    dir_rows.push_back(row_item(10'd14));
    dir_rows.push_back(row_item(10'd20));
    dir_rows.push_back(row_item(10'd341));
    dir_rows.push_back(row_reg(REG_COINS_IN_USE, 10'd5));
    dir_rows.push_back(row_item(10'd11));

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    last_reg = 1'b1;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_REG) begin
        if (!last_reg) begin
          wait_idle();
          settings_seen++;
        end
        write_reg(row.idx, row.val);
        last_reg = 1'b1;
      end else begin
        push_target(row.val[TARGET_W-1:0], row.known, row.coins, row.unreach);
        last_reg = 1'b0;
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 12; recv_idle_pct = 53; end
        1: begin send_idle_pct = 53; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int s = 0; s < int'(SETTINGS_PER_PHASE); s++) begin
        wait_idle();
        for (int k = 0; k < int'(COIN_REGS); k++) begin
          r = $urandom_range(99);
          if (r < 5) v = '0;
          else if (r < 10) v = 10'd1023;
          else if (r < 40) v = COIN_W'($urandom_range(1, 9));
          else v = COIN_W'($urandom_range(1, 60));
          write_reg(cfg_reg_e'(k), v);
        end
        r = $urandom_range(99);
        if (r < 8) v = '0;
        else if (r < 18) v = COIN_W'($urandom_range(6, 7));
        else v = COIN_W'($urandom_range(1, 5));
        write_reg(REG_COINS_IN_USE, v);
        settings_seen++;
        for (int n = 0; n < int'(ITEMS_PER_SETTING); n++) begin
          r = $urandom_range(99);
          if (r < 4) t = '0;
          else if (r < 8) t = 10'd1023;
          else if (r < 20) t = TARGET_W'($urandom_range(0, 1023));
          else t = TARGET_W'($urandom_range(0, 160));
          push_target(t, 1'b0, '0, 1'b0);
        end
      end
    end

    wait_idle();
    $display("summary: %0d items over %0d coin settings, %0d results checked, %0d register writes",
             items_sent, settings_seen, results_seen, reg_writes);
    $display("summary: %0d mismatching results", bad_results);
    if (bad_results == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
